@@ sv/kmeans_assign_update_core_macros.svh @@
// Assertion macros shared by the k-means core
`ifndef KMEANS_ASSIGN_UPDATE_CORE_MACROS_SVH
`define KMEANS_ASSIGN_UPDATE_CORE_MACROS_SVH

// Implication checked every cycle outside reset
`define KM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication outside reset
`define KM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ sv/kmau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kmau_pkg;
  localparam int MaxK = 8;
  localparam int MaxPoints = 65536;
  localparam int CntW = 17;
  localparam int SumW = 33;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } km_in_t;

  typedef struct packed {
    logic [2:0]         cluster;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic [16:0]        members;
    logic               empty_cluster;
    logic               last;
  } km_out_t;

  // Contents of one cell, handed to the neighbour on rotation
  typedef struct packed {
    logic signed [15:0]     cx;
    logic signed [15:0]     cy;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic [CntW-1:0]        cnt;
  } km_cell_t;

  // Control from the sequencer to the row of cells
  typedef struct packed {
    logic               rotate;
    logic               load;
    logic               acc;
    logic               fin;
    logic [2:0]         sel;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } km_ctrl_t;
endpackage
`default_nettype wire

@@ sv/kmau_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One cluster slot: holds its centroid and accumulators, passes them on rotation
module kmau_cell import kmau_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic [2:0] idx,
  input  km_ctrl_t      ctrl,
  input  km_cell_t      prev,
  output km_cell_t      cur
);
  km_cell_t cell_r, cell_nxt;
  assign cur = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    if (ctrl.rotate) begin
      cell_nxt = prev;
      // cluster leaving the head on a finish walk: cleared sums, and a new centroid when load is set
      if (ctrl.fin && idx == 3'(MaxK - 1)) begin
        if (ctrl.load) begin
          cell_nxt.cx = ctrl.mx;
          cell_nxt.cy = ctrl.my;
        end
        cell_nxt.sx  = '0;
        cell_nxt.sy  = '0;
        cell_nxt.cnt = '0;
      end
    end else if (ctrl.load && ctrl.sel == idx) begin
      cell_nxt.cx = ctrl.px;
      cell_nxt.cy = ctrl.py;
    end else if (ctrl.acc && ctrl.sel == idx &&
                 cell_r.cnt < CntW'(MaxPoints)) begin
      cell_nxt.cnt = cell_r.cnt + 1'b1;
      cell_nxt.sx  = cell_r.sx + SumW'(ctrl.px);
      cell_nxt.sy  = cell_r.sy + SumW'(ctrl.py);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cell_r <= '0;
    else        cell_r <= cell_nxt;
  end
endmodule
`default_nettype wire

@@ sv/kmau_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit a cycle, signed dividend, truncation to zero
module kmau_div import kmau_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [SumW-1:0] num,
  input  wire logic [CntW-1:0]      den,
  output logic                      done,
  output logic signed [15:0]        quo
);
  logic [SumW-1:0] q_r, q_nxt;
  logic [CntW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] den_r;
  logic            neg_r, busy_r;
  logic [5:0]      cnt_r;
  logic [CntW:0]   trial;
  logic [SumW-1:0] qs;

  always_comb begin
    trial   = {rem_r[CntW-1:0], q_r[SumW-1]};
    rem_nxt = trial;
    q_nxt   = {q_r[SumW-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
    qs = neg_r ? (~q_r + 1'b1) : q_r;
  end
  assign quo  = qs[15:0];
  assign done = busy_r && cnt_r == 6'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(SumW);
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[SumW-1] ? (~num + 1'b1) : num;
      neg_r <= num[SumW-1];
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r && cnt_r != 6'd0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/kmau_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "kmeans_assign_update_core_macros.svh"
// Sequencer: walks the ring of cells, one cluster per cycle at the head while a point is scanned
module kmau_seq import kmau_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  km_in_t      in_data,
  input  wire logic [3:0] k_cfg,
  input  km_cell_t    head,
  output km_ctrl_t    ctrl,
  output logic        out_valid,
  input  wire logic   out_stall,
  output km_out_t     out_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_ACC = 6'b000100,
    S_DIVX = 6'b001000, S_DIVY = 6'b010000, S_EMIT = 6'b100000
  } st_t;
  st_t st_r, st_nxt;
  logic [2:0] step_r;
  logic [2:0] best_r;
  logic [33:0] bestd_r;
  logic [CntW-1:0] bestn_r;
  logic signed [15:0] px_r, py_r, mx_r, my_r;
  logic restart_r;
  logic [3:0] k_eff;
  logic signed [16:0] dx, dy;
  logic [33:0] dxx, dyy, dsq;
  logic dstart, ddone;
  logic signed [SumW-1:0] dnum;
  logic signed [15:0] dq;
  logic accept;
  logic out_free;

  assign k_eff = (k_cfg == 4'd0) ? 4'd1 : (k_cfg > 4'(MaxK)) ? 4'(MaxK) : k_cfg;
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = st_r != S_IDLE;

  // distance of the point to the centroid at the head of the ring
  assign dx = 17'(px_r) - 17'(head.cx);
  assign dy = 17'(py_r) - 17'(head.cy);
  assign dxx = $unsigned(34'(dx) * 34'(dx));
  assign dyy = $unsigned(34'(dy) * 34'(dy));
  assign dsq = dxx + dyy;

  // y division starts as the x division completes
  assign dnum = (st_r == S_DIVX && ddone) ? head.sy : head.sx;
  kmau_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(head.cnt),
                  .done(ddone), .quo(dq));

  always_comb begin
    st_nxt = st_r;
    ctrl = '0;
    ctrl.px = px_r;
    ctrl.py = py_r;
    ctrl.mx = mx_r;
    ctrl.my = my_r;
    ctrl.sel = 3'd0;
    dstart = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            CMD_LOAD: begin
              ctrl.load = 1'b1;
              ctrl.sel = in_data.slot;
              ctrl.px = in_data.coord_x;
              ctrl.py = in_data.coord_y;
            end
            CMD_POINT: st_nxt = S_SCAN;
            CMD_FINISH: begin
              st_nxt = S_DIVX;
              dstart = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.rotate = 1'b1;
        if (step_r == 3'(MaxK - 1)) st_nxt = S_ACC;
      end
      S_ACC: if (out_free) begin
        ctrl.acc = 1'b1;
        ctrl.sel = best_r;
        st_nxt = S_IDLE;
      end
      S_DIVX: begin
        dstart = restart_r;
        if (ddone) begin
          st_nxt = S_DIVY;
          dstart = 1'b1;
        end
      end
      S_DIVY: if (ddone) st_nxt = S_EMIT;
      S_EMIT: if (out_free) begin
        ctrl.rotate = 1'b1;
        ctrl.fin = 1'b1;
        ctrl.load = 4'(step_r) < k_eff;
        if (step_r == 3'(MaxK - 1)) begin
          st_nxt = S_IDLE;
        end else if (4'(step_r) + 4'd1 < k_eff) begin
          st_nxt = S_DIVX;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Each active cluster leaves the head with its new mean, every cluster with cleared
  // sums; the eighth rotation of a finish brings the ring back to its home position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      step_r <= '0;
      out_valid <= 1'b0;
      restart_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      restart_r <= st_r == S_EMIT && st_nxt == S_DIVX;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (st_r == S_IDLE) step_r <= '0;
      else if (ctrl.rotate) step_r <= step_r + 1'b1;
      if (st_r == S_ACC && out_free) out_valid <= 1'b1;
      if (st_r == S_EMIT && out_free && 4'(step_r) < k_eff) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_data.coord_x;
      py_r <= in_data.coord_y;
    end
    if (st_r == S_SCAN && 4'(step_r) < k_eff && (step_r == 3'd0 || dsq < bestd_r)) begin
      bestd_r <= dsq;
      best_r <= step_r;
      bestn_r <= head.cnt;
    end
    if (st_r == S_DIVX && ddone) mx_r <= (head.cnt == '0) ? '0 : dq;
    if (st_r == S_DIVY && ddone) my_r <= (head.cnt == '0) ? '0 : dq;
    if (st_r == S_ACC && out_free) begin
      out_data.cluster <= best_r;
      out_data.mean_x <= '0;
      out_data.mean_y <= '0;
      out_data.members <= (bestn_r < CntW'(MaxPoints)) ? bestn_r + 1'b1 : bestn_r;
      out_data.empty_cluster <= 1'b0;
      out_data.last <= 1'b1;
    end
    if (st_r == S_EMIT && out_free && 4'(step_r) < k_eff) begin
      out_data.cluster <= step_r;
      out_data.mean_x <= mx_r;
      out_data.mean_y <= my_r;
      out_data.members <= head.cnt;
      out_data.empty_cluster <= head.cnt == '0;
      out_data.last <= 4'(step_r) + 4'd1 == k_eff;
    end
  end

  `KM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, in_stall)
  `KM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `KM_ASSERT_IMP(a_acc_best, clk, rst_n, st_r == S_ACC, 4'(best_r) < k_eff)
endmodule
`default_nettype wire

@@ sv/kmeans_assign_update_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// k-means (2-D) assign/update core.
// Input channel in_valid/in_stall carries km_in_t commands: load centroid,
// classify point, finish pass. Results leave on out_valid/out_stall as km_out_t.
// Configuration: cfg_valid/cfg_ready writes k (active clusters); write only
// while idle. cfg_ready is always high.
// The eight clusters sit in a ring of cells that rotates one place a cycle while a
// point is scanned, and one place per cluster as a finish walks the clusters.
// Load: writes one centroid, no result. Point: all eight cells rotate past the
// distance unit, then, once the output is free, the nearest cluster accumulates the
// point and the result is registered; the next command can transfer while it is valid.
// Finish: per active cluster two 33-bit serial divisions, x then y, then one output;
// the x division of each later cluster starts from a registered restart flag, and
// each inactive cluster takes one rotation with no output.
// While the receiver stalls, the core holds its result and waits; no new
// input is taken until the current command has finished.
// Reset (rst_n low, synchronous) clears all centroids and sums, sets k to 8.
module kmeans_assign_update_core import kmau_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  km_in_t      in_data,
  output logic        out_valid,
  input  wire logic   out_stall,
  output km_out_t     out_data,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire logic [3:0] cfg_data
);
  logic [3:0] k_r;
  km_ctrl_t ctrl;
  km_cell_t cells [MaxK];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= 4'd8;
    else if (cfg_valid) k_r <= cfg_data;
  end

  // ring: cell i takes from cell i+1, head is cell 0
  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    kmau_cell u_cell (.clk, .rst_n, .idx(3'(i)), .ctrl,
                      .prev(cells[(i + 1) % MaxK]), .cur(cells[i]));
  end

  kmau_seq u_seq (.clk, .rst_n, .in_valid, .in_stall, .in_data, .k_cfg(k_r),
                  .head(cells[0]), .ctrl, .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

@@ tb/kmeans_assign_update_checker.sv @@
`timescale 1ns / 1ps
module kmeans_assign_update_checker import kmau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  km_in_t     in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  km_out_t    out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  // Model state of the core
  logic [3:0]             k_reg;
  logic signed [15:0]     cen_x [MaxK];
  logic signed [15:0]     cen_y [MaxK];
  logic signed [SumW-1:0] acc_x [MaxK];
  logic signed [SumW-1:0] acc_y [MaxK];
  logic [CntW-1:0]        acc_n [MaxK];
  km_out_t                expected_results [$];

  assign pending = expected_results.size();

  function automatic int active_k();
    int k;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > MaxK) k = MaxK;
    return k;
  endfunction

  // Work out the results of one command and update the model
  task automatic predict_command(input km_in_t c);
    int k;
    int best;
    longint d;
    longint best_d;
    longint dx;
    longint dy;
    longint mx;
    longint my;
    km_out_t r;
    k = active_k();
    case (c.cmd)
      CMD_LOAD: begin
        cen_x[c.slot] = c.coord_x;
        cen_y[c.slot] = c.coord_y;
      end
      CMD_POINT: begin
        best = 0;
        best_d = 0;
        for (int j = 0; j < k; j++) begin
          dx = longint'(c.coord_x) - longint'(cen_x[j]);
          dy = longint'(c.coord_y) - longint'(cen_y[j]);
          d = dx * dx + dy * dy;
          if (j == 0 || d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        if (acc_n[best] < MaxPoints) begin
          acc_n[best] = acc_n[best] + 1;
          acc_x[best] = acc_x[best] + c.coord_x;
          acc_y[best] = acc_y[best] + c.coord_y;
        end
        r = '0;
        r.cluster = best[2:0];
        r.members = acc_n[best];
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      CMD_FINISH: begin
        for (int j = 0; j < k; j++) begin
          mx = 0;
          my = 0;
          if (acc_n[j] != 0) begin
            mx = longint'(acc_x[j]) / longint'(acc_n[j]);
            my = longint'(acc_y[j]) / longint'(acc_n[j]);
          end
          cen_x[j] = mx[15:0];
          cen_y[j] = my[15:0];
          r.cluster = j[2:0];
          r.mean_x = mx[15:0];
          r.mean_y = my[15:0];
          r.members = acc_n[j];
          r.empty_cluster = (acc_n[j] == 0);
          r.last = (j == k - 1);
          expected_results.push_back(r);
        end
        for (int j = 0; j < MaxK; j++) begin
          acc_x[j] = '0;
          acc_y[j] = '0;
          acc_n[j] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Compare one result with the oldest expectation
  task automatic check_result(input km_out_t a);
    km_out_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %p", $time, a);
      fail_count++;
    end else begin
      e = expected_results.pop_front();
      if (a.cluster != e.cluster || a.mean_x != e.mean_x || a.mean_y != e.mean_y ||
          a.members != e.members || a.empty_cluster != e.empty_cluster ||
          a.last != e.last) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, a);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      k_reg <= 4'd8;
      for (int j = 0; j < MaxK; j++) begin
        cen_x[j] = '0;
        cen_y[j] = '0;
        acc_x[j] = '0;
        acc_y[j] = '0;
        acc_n[j] = '0;
      end
      expected_results = {};
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict_command(in_data);
      if (cfg_valid && cfg_ready) k_reg <= cfg_data;
    end
  end
endmodule

@@ tb/tb_kmeans_assign_update_core.sv @@
`timescale 1ns / 1ps
module tb_kmeans_assign_update_core;
  import kmau_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 700;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  km_in_t     in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  km_out_t    out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  bit         calm = 1'b0;
  int         idle_cycles = 0;

  always #10 clk = ~clk;

  kmeans_assign_update_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  kmeans_assign_update_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls at random except in calm stretches
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 26);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL kmeans_assign_update_core");
      $finish;
    end
  end

  // One command transfer, with an optional random gap before it
  task automatic send_command(input logic [1:0] cmd, input logic [2:0] slot,
                              input logic [15:0] x, input logic [15:0] y);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, slot: slot, coord_x: x, coord_y: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_transfer();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write k once everything has drained
  task automatic set_k(input logic [3:0] k);
    end_transfer();
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random pass: loads, a run of mostly points with some loads and unused commands, then a finish
  task automatic random_pass(input int npoints);
    int r;
    for (int j = 0; j < $urandom_range(8, 1); j++)
      send_command(CMD_LOAD, 3'($urandom), rand_coord(), rand_coord());
    for (int j = 0; j < npoints; j++) begin
      r = $urandom_range(99);
      if (r < 4) send_command(2'd3, 3'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 8) send_command(CMD_LOAD, 3'($urandom), rand_coord(), rand_coord());
      else send_command(CMD_POINT, 3'($urandom), rand_coord(), rand_coord());
    end
    send_command(CMD_FINISH, 3'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, ties, empty clusters, unused command
    send_command(CMD_FINISH, 3'd0, 16'd0, 16'd0);
    send_command(CMD_LOAD, 3'd0, 16'h8000, 16'h8000);
    send_command(CMD_LOAD, 3'd7, 16'h7FFF, 16'h7FFF);
    send_command(CMD_LOAD, 3'd3, 16'd10, 16'hFFF6);
    send_command(CMD_POINT, 3'd5, 16'h7FFF, 16'h7FFF);
    send_command(CMD_POINT, 3'd0, 16'h8000, 16'h8000);
    send_command(CMD_POINT, 3'd2, 16'h8000, 16'h7FFF);
    send_command(CMD_POINT, 3'd0, 16'd0, 16'd0);
    send_command(CMD_POINT, 3'd0, 16'd5, 16'hFFFB);
    send_command(CMD_POINT, 3'd0, 16'hFFFF, 16'hFFFD);
    send_command(2'd3, 3'd7, 16'hFFFF, 16'hFFFF);
    send_command(CMD_FINISH, 3'd7, 16'hFFFF, 16'hFFFF);
    // Tie between two equal centroids goes to the lower index
    send_command(CMD_LOAD, 3'd1, 16'd4, 16'd4);
    send_command(CMD_LOAD, 3'd2, 16'd4, 16'd4);
    send_command(CMD_POINT, 3'd0, 16'd4, 16'd4);
    send_command(CMD_FINISH, 3'd0, 16'd0, 16'd0);

    // k of zero acts as one, large values saturate
    set_k(4'd0);
    send_command(CMD_POINT, 3'd0, 16'h1234, 16'hFEDC);
    send_command(CMD_FINISH, 3'd0, 16'd0, 16'd0);
    set_k(4'd15);
    random_pass(6);
    set_k(4'd1);
    random_pass(8);

    // Calm stretch with no idling on either side
    calm = 1'b1;
    set_k(4'd8);
    random_pass(40);
    calm = 1'b0;

    for (int p = 0; p < 6; p++) begin
      set_k(4'($urandom_range(8, 2)));
      random_pass(20);
    end
    set_k(4'd8);
    random_pass(10);
    end_transfer();

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) $display("PASS kmeans_assign_update_core");
    else $display("FAIL kmeans_assign_update_core");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/kmau_pkg.sv
sv/kmau_cell.sv
sv/kmau_div.sv
sv/kmau_seq.sv
sv/kmeans_assign_update_core.sv
tb/kmeans_assign_update_checker.sv
tb/tb_kmeans_assign_update_core.sv
